// ===== rtl/core/mmb_pkg.sv =====
// Package for the console memory map: action, region and state codes, bus structs, constants, decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmb_pkg;
	localparam int DmaLengthDefault = 160;
	localparam int OamDepth = 160;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		RG_ROM, RG_VRAM, RG_EXT, RG_WRAM, RG_OAM, RG_UNUSED,
		RG_JOYP, RG_IFLAG, RG_IO, RG_HRAM, RG_IE
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACCESS, ST_DMA_READ, ST_DMA_WRITE, ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic access;
		logic dma_start;
		logic dma_read;
		logic dma_write;
		logic finish;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_dma;
		logic dma_last;
	} stat_t;

	localparam logic [7:0] TimerOrMask = 8'hF8;
	localparam logic [7:0] FlagOrMask  = 8'hE0;
	localparam logic [7:0] OpenBus     = 8'hFF;
	localparam logic [6:0] RegJoyp  = 7'h00;
	localparam logic [6:0] RegDiv   = 7'h04;
	localparam logic [6:0] RegTac   = 7'h07;
	localparam logic [6:0] RegIflag = 7'h0F;
	localparam logic [6:0] RegLy    = 7'h44;
	localparam logic [6:0] RegDma   = 7'h46;

	function automatic region_t decode(input logic [15:0] a);
		region_t r;
		if (a[15] == 1'b0) r = RG_ROM;
		else if (a[15:13] == 3'b100) r = RG_VRAM;
		else if (a[15:13] == 3'b101) r = RG_EXT;
		else if (a[15:13] == 3'b110 || a[15:12] == 4'hE) r = RG_WRAM;
		else if (a[15:8] < 8'hFE) r = RG_WRAM;
		else if (a[15:8] == 8'hFE) r = (a[7:0] < 8'hA0) ? RG_OAM : RG_UNUSED;
		else if (a[7:0] == 8'h00) r = RG_JOYP;
		else if (a[7:0] == 8'h0F) r = RG_IFLAG;
		else if (a[7] == 1'b0) r = RG_IO;
		else if (a[7:0] == 8'hFF) r = RG_IE;
		else r = RG_HRAM;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/memory_map_bus_with_oam_dma.sv =====
// Ordinary accesses: the result word is registered in the access state, and no new request is
// taken while busy. A DMA write holds busy through the access state, then a read and a write
// state per byte, one per port, then a done state. Results are strobed by done for one cycle.
// Reset clears control, I/O, flag and enable registers; RAM contents stay undefined.
// Depends on mmb_pkg, mmb_ctrl and mmb_datapath.
`timescale 1ns / 1ps
`default_nettype none
module memory_map_bus_with_oam_dma #(
	parameter int DMA_LENGTH = mmb_pkg::DmaLengthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	input  wire logic [7:0]  buttons,
	output logic             done,
	output logic [7:0]       read_data,
	output logic             divider_cleared,
	output logic             timer_restarted
);
	mmb_pkg::ctrl_t ctrl;
	mmb_pkg::stat_t stat;

	mmb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ctrl(ctrl), .stat(stat)
	);

	mmb_datapath #(.DMA_LENGTH(DMA_LENGTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.action(action), .address(address), .data(data), .buttons(buttons),
		.done(done), .read_data(read_data),
		.divider_cleared(divider_cleared), .timer_restarted(timer_restarted)
	);
endmodule
`default_nettype wire

// ===== rtl/core/mmb_ctrl.sv =====
// Controller state machine for the memory map.
// Depends on mmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output mmb_pkg::ctrl_t     ctrl,
	input  mmb_pkg::stat_t     stat
);
	mmb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mmb_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmb_pkg::ST_IDLE: if (start) state_d = mmb_pkg::ST_ACCESS;
			mmb_pkg::ST_ACCESS: state_d = stat.is_dma ? mmb_pkg::ST_DMA_READ : mmb_pkg::ST_IDLE;
			mmb_pkg::ST_DMA_READ: state_d = mmb_pkg::ST_DMA_WRITE;
			mmb_pkg::ST_DMA_WRITE: state_d = stat.dma_last ? mmb_pkg::ST_DONE
				: mmb_pkg::ST_DMA_READ;
			mmb_pkg::ST_DONE: state_d = mmb_pkg::ST_IDLE;
			default: state_d = mmb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			mmb_pkg::ST_IDLE: begin
				busy = 1'b0;
				ctrl.capture = start;
			end
			mmb_pkg::ST_ACCESS: begin
				ctrl.access = 1'b1;
				ctrl.dma_start = stat.is_dma;
			end
			mmb_pkg::ST_DMA_READ: ctrl.dma_read = 1'b1;
			mmb_pkg::ST_DMA_WRITE: ctrl.dma_write = 1'b1;
			mmb_pkg::ST_DONE: ctrl.finish = 1'b1;
			default: busy = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/mmb_datapath.sv =====
// Datapath for the memory map: stores, registers, read mux and DMA counter.
// Depends on mmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmb_datapath #(
	parameter int DMA_LENGTH = mmb_pkg::DmaLengthDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  mmb_pkg::ctrl_t  ctrl,
	output mmb_pkg::stat_t  stat,
	input  wire logic [1:0] action,
	input  wire logic [15:0] address,
	input  wire logic [7:0] data,
	input  wire logic [7:0] buttons,
	output logic            done,
	output logic [7:0]      read_data,
	output logic            divider_cleared,
	output logic            timer_restarted
);
	localparam int CntW = $clog2(DMA_LENGTH + 1);

	logic [7:0] rom_mem [32768];
	logic [7:0] vram_mem [8192];
	logic [7:0] wram_mem [8192];
	logic [7:0] oam_mem [mmb_pkg::OamDepth];
	logic [7:0] hram_mem [128];
	logic [7:0] io_q [128];
	logic [7:0] iflag_q, ie_q;

	logic [1:0]  act_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q, btn_q;
	logic [CntW-1:0] cnt_q;
	logic [7:0] page_q;

	logic [7:0] rom_rd, vram_rd, wram_rd, oam_rd, hram_rd, io_rd;
	mmb_pkg::region_t reg_q;

	// Address used for reading: the incoming bus address on capture, the DMA source, else the held address.
	logic [15:0] raddr;
	logic [15:0] src;
	assign src = {page_q, 8'h00} + 16'(cnt_q);
	assign raddr = ctrl.capture ? address : ((ctrl.dma_read) ? src : addr_q);

	mmb_pkg::region_t cur_reg, rreg;
	assign cur_reg = mmb_pkg::decode(addr_q);
	assign rreg = mmb_pkg::decode(raddr);

	logic [12:0] wram_idx;
	assign wram_idx = (raddr[15:13] == 3'b110) ? raddr[12:0] : {1'b0, raddr[11:0]} |
		((raddr[15:12] == 4'hF) ? 13'h1000 : 13'h0000);

	logic is_write, is_dma;
	assign is_write = (mmb_pkg::action_t'(act_q) == mmb_pkg::ACT_WRITE);
	assign is_dma = is_write && cur_reg == mmb_pkg::RG_IO && addr_q[6:0] == mmb_pkg::RegDma;
	assign stat.is_dma = is_dma;
	assign stat.dma_last = (cnt_q == CntW'(DMA_LENGTH - 1));

	logic [7:0] joyp;
	always_comb begin
		joyp = ~io_q[mmb_pkg::RegJoyp];
		if (!joyp[4]) joyp = joyp & ({4'h0, btn_q[7:4]} | 8'hF0);
		else if (!joyp[5]) joyp = joyp & ({4'h0, btn_q[3:0]} | 8'hF0);
	end

	// Registered memory reads, available in the cycle after capture or a DMA read.
	always_ff @(posedge clk) begin
		rom_rd  <= rom_mem[raddr[14:0]];
		vram_rd <= vram_mem[raddr[12:0]];
		wram_rd <= wram_mem[wram_idx];
		oam_rd  <= oam_mem[(raddr[7:0] < 8'hA0) ? raddr[7:0] : 8'h00];
		hram_rd <= hram_mem[raddr[6:0]];
		io_rd   <= io_q[raddr[6:0]];
		reg_q   <= rreg;
	end

	logic [7:0] rmux;
	always_comb begin
		unique case (reg_q)
			mmb_pkg::RG_ROM:   rmux = rom_rd;
			mmb_pkg::RG_VRAM:  rmux = vram_rd;
			mmb_pkg::RG_EXT:   rmux = mmb_pkg::OpenBus;
			mmb_pkg::RG_WRAM:  rmux = wram_rd;
			mmb_pkg::RG_OAM:   rmux = oam_rd;
			mmb_pkg::RG_JOYP:  rmux = joyp;
			mmb_pkg::RG_IFLAG: rmux = iflag_q;
			mmb_pkg::RG_IO:    rmux = io_rd;
			mmb_pkg::RG_HRAM:  rmux = hram_rd;
			mmb_pkg::RG_IE:    rmux = ie_q;
			default:           rmux = 8'h00;
		endcase
	end

	// Write side: one bus write in the access cycle, or one DMA byte.
	logic        we;
	logic [15:0] waddr;
	logic [7:0]  wdata;
	mmb_pkg::region_t wreg;
	logic [12:0] wram_widx;
	assign we = (ctrl.access && is_write && !is_dma) || ctrl.dma_write;
	assign waddr = ctrl.dma_write ? (16'hFE00 + 16'(cnt_q)) : addr_q;
	assign wdata = ctrl.dma_write ? rmux : data_q;
	assign wreg = mmb_pkg::decode(waddr);
	assign wram_widx = (waddr[15:13] == 3'b110) ? waddr[12:0] : {1'b0, waddr[11:0]} |
		((waddr[15:12] == 4'hF) ? 13'h1000 : 13'h0000);

	always_ff @(posedge clk) begin
		if (ctrl.access && mmb_pkg::action_t'(act_q) == mmb_pkg::ACT_LOAD && !addr_q[15])
			rom_mem[addr_q[14:0]] <= data_q;
		if (we && wreg == mmb_pkg::RG_VRAM) vram_mem[waddr[12:0]] <= wdata;
		if (we && wreg == mmb_pkg::RG_WRAM) wram_mem[wram_widx] <= wdata;
		if (we && wreg == mmb_pkg::RG_OAM) oam_mem[waddr[7:0]] <= wdata;
		if (we && wreg == mmb_pkg::RG_HRAM) hram_mem[waddr[6:0]] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 128; i++) io_q[i] <= 8'h00;
			iflag_q <= 8'h00;
			ie_q <= 8'h00;
		end else if (we) begin
			if (wreg == mmb_pkg::RG_IE) ie_q <= wdata;
			if (wreg == mmb_pkg::RG_IFLAG) iflag_q <= wdata | mmb_pkg::FlagOrMask;
			if (wreg == mmb_pkg::RG_IO || wreg == mmb_pkg::RG_JOYP) begin
				unique case (waddr[6:0])
					mmb_pkg::RegDiv, mmb_pkg::RegLy: io_q[waddr[6:0]] <= 8'h00;
					mmb_pkg::RegTac: io_q[waddr[6:0]] <= wdata | mmb_pkg::TimerOrMask;
					default: io_q[waddr[6:0]] <= wdata;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			act_q <= action;
			addr_q <= address;
			data_q <= data;
			btn_q <= buttons;
		end
		if (ctrl.dma_start) begin
			page_q <= data_q;
			cnt_q <= '0;
		end else if (ctrl.dma_write) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			read_data <= 8'h00;
			divider_cleared <= 1'b0;
			timer_restarted <= 1'b0;
		end else begin
			done <= (ctrl.access && !is_dma) || ctrl.finish;
			if (ctrl.access && !is_dma) begin
				read_data <= (mmb_pkg::action_t'(act_q) == mmb_pkg::ACT_READ) ? rmux : 8'h00;
				divider_cleared <= is_write && cur_reg == mmb_pkg::RG_IO
					&& addr_q[6:0] == mmb_pkg::RegDiv;
				timer_restarted <= is_write && cur_reg == mmb_pkg::RG_IO
					&& addr_q[6:0] == mmb_pkg::RegTac;
			end else if (ctrl.finish) begin
				read_data <= 8'h00;
				divider_cleared <= 1'b0;
				timer_restarted <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
